### rtl/lap_pkg.sv
// package for the 3x3 laplacian window filter
// image geometry and sample widths used by all modules, and the window column type
// no dependencies
`timescale 1ns / 1ps

package lap_pkg;

  // image is ImageSize x ImageSize samples
  localparam int ImageSize = 64;
  localparam int CntW      = $clog2(ImageSize);
  localparam int KernelSpan = 3;

  // sample and result widths
  localparam int PixW    = 16;
  localparam int ColSumW = PixW + 2;
  localparam int OutW    = 20;
  localparam int AccW    = OutW + 2;

  // one window column, oldest row first
  typedef struct packed {
    logic signed [PixW-1:0] top;
    logic signed [PixW-1:0] mid;
    logic signed [PixW-1:0] bot;
  } lap_col_t;

endpackage

### rtl/lap_line_buf.sv
// two line stores holding the previous two image rows
// uses lap_pkg for the row length and sample width
`timescale 1ns / 1ps

module lap_line_buf
  import lap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [CntW-1:0]        rd_addr_i,
  input  logic                   wr1_en_i,
  input  logic [CntW-1:0]        wr1_addr_i,
  input  logic signed [PixW-1:0] wr1_data_i,
  input  logic                   wr2_en_i,
  input  logic [CntW-1:0]        wr2_addr_i,
  input  logic signed [PixW-1:0] wr2_data_i,
  output logic signed [PixW-1:0] rd1_o,
  output logic signed [PixW-1:0] rd2_o
);

  logic signed [PixW-1:0] line1_mem [ImageSize];
  logic signed [PixW-1:0] line2_mem [ImageSize];
  logic signed [PixW-1:0] rd1_q;
  logic signed [PixW-1:0] rd2_q;

  // row r-1 store, read before write at the same address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd1_q <= line1_mem[rd_addr_i];
    end
    if (wr1_en_i) begin
      line1_mem[wr1_addr_i] <= wr1_data_i;
    end
  end

  // row r-2 store, written from stage 1 with the row r-1 sample read from the row r-1 store
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd2_q <= line2_mem[rd_addr_i];
    end
    if (wr2_en_i) begin
      line2_mem[wr2_addr_i] <= wr2_data_i;
    end
  end

  assign rd1_o = rd1_q;
  assign rd2_o = rd2_q;

endmodule

### rtl/lap_cell.sv
// one window column cell: holds a column and its registered sum
// uses lap_pkg for the column type and widths
`timescale 1ns / 1ps

module lap_cell
  import lap_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  lap_col_t                  col_i,
  output lap_col_t                  col_o,
  output logic signed [ColSumW-1:0] colsum_o
);

  lap_col_t                  col_q;
  logic signed [ColSumW-1:0] colsum_q;
  logic signed [ColSumW-1:0] colsum_d;

  // sum of the incoming column
  always_comb begin
    colsum_d = ColSumW'(col_i.top) + ColSumW'(col_i.mid) + ColSumW'(col_i.bot);
  end

  // take the neighbor's column on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      colsum_q <= '0;
    end else if (shift_i) begin
      col_q    <= col_i;
      colsum_q <= colsum_d;
    end
  end

  assign col_o    = col_q;
  assign colsum_o = colsum_q;

endmodule

### rtl/laplacian_3x3_window_filter_top.sv
// 3x3 laplacian filter over a raster image stream, top level
// uses lap_pkg, lap_line_buf and a chain of three lap_cell columns
//
//   channel | handshake             | payload
//   in      | in_valid_i/in_ready_o | pixel_i, frame_start_i
//   out     | out_valid_o/out_ready_i | filtered_o, frame_last_o
//
// one pixel per cycle while the output is not stalled; a result passes stage 1, the cells and the output register
// pipeline: line store read, column cell shift, kernel sum into output register
// all stages advance together whenever the output register is free or drained
// reset clears counters, stage valids and the window cells; line stores are not cleared
// a stalled output holds the whole pipe and drops in_ready_o
`timescale 1ns / 1ps

module laplacian_3x3_window_filter_top
  import lap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [PixW-1:0] pixel_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] filtered_o,
  output logic                   frame_last_o
);

  localparam logic [CntW-1:0] LastIdx = CntW'(ImageSize - 1);
  localparam logic [CntW-1:0] FirstWin = CntW'(KernelSpan - 1);

  logic adv;
  logic in_req;

  // counters
  logic [CntW-1:0] row_cnt_q, row_cnt_d;
  logic [CntW-1:0] col_cnt_q, col_cnt_d;
  logic [CntW-1:0] row_cur, col_cur;

  // stage 1: line store read pending
  logic                   s1_valid_q;
  logic                   s1_emit_q;
  logic                   s1_last_q;
  logic [CntW-1:0]        s1_col_q;
  logic signed [PixW-1:0] s1_pix_q;

  // stage 2: window complete in the cells
  logic s2_valid_q;
  logic s2_last_q;

  // output register
  logic                   out_valid_q;
  logic signed [OutW-1:0] filtered_q;
  logic                   frame_last_q;

  logic signed [PixW-1:0]    line1_rd, line2_rd;
  lap_col_t                  new_col;
  lap_col_t                  cell_col [KernelSpan];
  lap_col_t                  cell_in  [KernelSpan];
  logic signed [ColSumW-1:0] cell_sum [KernelSpan];
  logic                      cell_shift;

  logic signed [AccW-1:0] centre_x;
  logic signed [AccW-1:0] win_sum;
  logic signed [AccW-1:0] kernel_acc;

  assign adv    = !out_valid_q || out_ready_i;
  assign in_req = in_valid_i && adv;

  // position of the incoming pixel, frame start forces the origin
  always_comb begin
    row_cur = frame_start_i ? '0 : row_cnt_q;
    col_cur = frame_start_i ? '0 : col_cnt_q;
    if (col_cur == LastIdx) begin
      col_cnt_d = '0;
      row_cnt_d = (row_cur == LastIdx) ? '0 : row_cur + 1'b1;
    end else begin
      col_cnt_d = col_cur + 1'b1;
      row_cnt_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (in_req) begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
    end
  end

  // line stores
  lap_line_buf u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (in_req),
    .rd_addr_i  (col_cur),
    .wr1_en_i   (in_req),
    .wr1_addr_i (col_cur),
    .wr1_data_i (pixel_i),
    .wr2_en_i   (s1_valid_q && adv),
    .wr2_addr_i (s1_col_q),
    .wr2_data_i (line1_rd),
    .rd1_o      (line1_rd),
    .rd2_o      (line2_rd)
  );

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s1_emit_q  <= (row_cur >= FirstWin) && (col_cur >= FirstWin);
      s1_last_q  <= (row_cur == LastIdx) && (col_cur == LastIdx);
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      s1_col_q <= col_cur;
      s1_pix_q <= pixel_i;
    end
  end

  // column chain, newest column enters cell 0
  assign new_col.top = line2_rd;
  assign new_col.mid = line1_rd;
  assign new_col.bot = s1_pix_q;
  assign cell_shift  = s1_valid_q && adv;

  for (genvar k = 0; k < KernelSpan; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_body
      assign cell_in[k] = cell_col[k-1];
    end
    lap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (cell_shift),
      .col_i    (cell_in[k]),
      .col_o    (cell_col[k]),
      .colsum_o (cell_sum[k])
    );
  end

  // stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // kernel: nine times centre minus the sum of all nine samples
  always_comb begin
    centre_x   = AccW'(cell_col[1].mid);
    win_sum    = AccW'(cell_sum[0]) + AccW'(cell_sum[1]) + AccW'(cell_sum[2]);
    kernel_acc = (centre_x <<< 3) + centre_x - win_sum;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      filtered_q   <= kernel_acc[OutW-1:0];
      frame_last_q <= s2_last_q;
    end
  end

  assign in_ready_o   = adv;
  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;
  assign frame_last_o = frame_last_q;

`ifndef SYNTHESIS
  // a taken request always occupies stage 1 next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("taken request missing from stage 1");

  // a stalled stage 1 keeps its column address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_col_q)))
    else $error("stage 1 changed during stall");

  // a covered window moving on always reaches stage 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && s1_emit_q) |=> s2_valid_q)
    else $error("window result lost between stages");

  // counters stay inside the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_cnt_q <= LastIdx) && (row_cnt_q <= LastIdx))
    else $error("position counter out of range");
`endif

endmodule
